>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/kfr_pkg.sv
// ----------------------------------------------------------------------------
// K-line frame receiver package
// Types and constants shared by the frame receiver modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kfr_pkg;

	localparam int MAX_FRAME_DEF = 80;

	localparam logic [15:0] TIMEOUT_RESET = 16'd400;

	localparam logic [7:0] FMT_MASK = 8'hC0;
	localparam logic [7:0] FMT_MARK = 8'h80;
	localparam logic [7:0] LEN_MASK = 8'h3F;

	localparam logic [2:0] HDR_SHORT = 3'd3;
	localparam logic [2:0] HDR_LONG  = 3'd4;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_GOOD    = 2'd1,
		KIND_BAD     = 2'd2,
		KIND_TIMEOUT = 2'd3
	} kind_t;

	typedef enum logic {
		CMD_BYTE = 1'b0,
		CMD_TICK = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [7:0]  rx_byte;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [6:0]  position;
		logic [6:0]  payload_length;
	} result_t;

endpackage

>>> rtl/kline_frame_receiver.sv
// A result is parsed from the input register and held in the result register.
// One item per cycle is taken while in_stall is low.
// The input register stalls only while the result register holds a stalled result.
// Reset (arst_n low) clears the search state, sets the timeout to 400 ticks
// and loads the tick budget with it.
// ----------------------------------------------------------------------------
// K-line frame receiver
// Parses ISO 14230 style frames from line bytes and millisecond ticks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module kline_frame_receiver #(
	parameter int MAX_FRAME = kfr_pkg::MAX_FRAME_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  data,
	output logic [6:0]  position,
	output logic [6:0]  payload_length,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	kfr_pkg::item_t   item;
	kfr_pkg::item_t   item_s1;
	kfr_pkg::result_t res;
	kfr_pkg::result_t result_s2;
	logic             valid_s1;
	logic             valid_s2;
	logic             res_valid;
	logic             out_free;
	logic             advance;
	logic             out_blocked;
	logic             out_timeout;
	logic             out_end;
	logic             out_zero;

	assign item.cmd     = kfr_pkg::cmd_t'(cmd);
	assign item.rx_byte = rx_byte;

	assign cfg_ready = 1'b1;
	assign out_free  = !valid_s2 || !out_stall;
	assign advance   = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;

	kfr_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.item     (item),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	kfr_parser #(
		.MAX_FRAME (MAX_FRAME)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.advance   (advance),
		.item_s1   (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	kfr_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load_en   (out_free),
		.res_valid (res_valid),
		.res       (res),
		.valid_s2  (valid_s2),
		.result_s2 (result_s2)
	);

	assign out_valid      = valid_s2;
	assign kind           = result_s2.kind;
	assign data           = result_s2.data;
	assign position       = result_s2.position;
	assign payload_length = result_s2.payload_length;

	assign out_blocked = valid_s2 && out_stall;
	assign out_timeout = out_valid && kind == kfr_pkg::KIND_TIMEOUT;
	assign out_end     = out_valid && kind != kfr_pkg::KIND_PAYLOAD;
	assign out_zero    = data == 8'd0 && position == 7'd0 && payload_length == 7'd0;

	`ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, in_valid && !in_stall, valid_s1, "lost item")
	`ASSERT_IMPL(a_stall_cause, clk, arst_n, in_stall, out_blocked && valid_s1, "spurious stall")
	`ASSERT_IMPL(a_timeout_clean, clk, arst_n, out_timeout, out_zero, "timeout fields not zero")
	`ASSERT_IMPL(a_end_position, clk, arst_n, out_end, position == 7'd0, "end with position")

endmodule

>>> rtl/kfr_in_reg.sv
// ----------------------------------------------------------------------------
// Input register
// Captures one accepted transaction and holds it while the parser is stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kfr_in_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_stall,
	input  kfr_pkg::item_t item,
	output logic           valid_s1,
	output kfr_pkg::item_t item_s1
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= item;
		end
	end

endmodule

>>> rtl/kfr_parser.sv
// ----------------------------------------------------------------------------
// Frame parser
// Holds the frame search state and turns one item into at most one result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kfr_parser #(
	parameter int MAX_FRAME = kfr_pkg::MAX_FRAME_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [15:0]      cfg_data,
	input  logic             advance,
	input  kfr_pkg::item_t   item_s1,
	output logic             res_valid,
	output kfr_pkg::result_t res
);

	localparam int CW = $clog2(MAX_FRAME + 1);
	localparam logic [8:0] MAX_TOTAL = 9'(MAX_FRAME);

	logic [15:0]   timeout_q;
	logic [15:0]   ticks_left_q, ticks_left_d;
	logic [CW-1:0] byte_count_q, byte_count_d;
	logic [CW-1:0] frame_size_q, frame_size_d;
	logic [7:0]    length_seen_q, length_seen_d;
	logic [2:0]    header_size_q, header_size_d;
	logic [7:0]    running_sum_q, running_sum_d;

	logic [7:0]    b;
	logic [7:0]    short_len;
	logic [8:0]    short_total;
	logic [8:0]    long_total;
	logic [7:0]    pos_full;
	logic [CW-1:0] count_inc;

	always_comb begin
		b           = item_s1.rx_byte;
		short_len   = b & kfr_pkg::LEN_MASK;
		short_total = 9'(kfr_pkg::HDR_SHORT) + 9'(short_len) + 9'd1;
		long_total  = 9'(header_size_q) + 9'(b) + 9'd1;
		pos_full    = 8'(byte_count_q) - 8'(header_size_q);
		count_inc   = byte_count_q + CW'(1);

		ticks_left_d  = ticks_left_q;
		byte_count_d  = byte_count_q;
		frame_size_d  = frame_size_q;
		length_seen_d = length_seen_q;
		header_size_d = header_size_q;
		running_sum_d = running_sum_q;
		res_valid     = 1'b0;
		res           = '0;

		if (advance) begin
			if (item_s1.cmd == kfr_pkg::CMD_TICK) begin
				if (ticks_left_q <= 16'd1) begin
					byte_count_d  = '0;
					frame_size_d  = '0;
					length_seen_d = '0;
					header_size_d = '0;
					running_sum_d = '0;
					ticks_left_d  = timeout_q;
					res_valid     = 1'b1;
					res.kind      = kfr_pkg::KIND_TIMEOUT;
				end else begin
					ticks_left_d = ticks_left_q - 16'd1;
				end
			end else if (byte_count_q == '0) begin
				if ((b & kfr_pkg::FMT_MASK) == kfr_pkg::FMT_MARK) begin
					if (short_len == '0) begin
						length_seen_d = '0;
						header_size_d = kfr_pkg::HDR_LONG;
						frame_size_d  = '0;
						running_sum_d = b;
						byte_count_d  = CW'(1);
					end else if (short_total <= MAX_TOTAL) begin
						length_seen_d = short_len;
						header_size_d = kfr_pkg::HDR_SHORT;
						frame_size_d  = CW'(short_total);
						running_sum_d = b;
						byte_count_d  = CW'(1);
					end
				end
			end else if (frame_size_q == '0 && byte_count_q == CW'(3)) begin
				if (b == '0 || long_total > MAX_TOTAL) begin
					byte_count_d  = '0;
					frame_size_d  = '0;
					length_seen_d = '0;
					header_size_d = '0;
					running_sum_d = '0;
				end else begin
					length_seen_d = b;
					frame_size_d  = CW'(long_total);
					running_sum_d = running_sum_q + b;
					byte_count_d  = CW'(4);
				end
			end else if (frame_size_q != '0 && count_inc == frame_size_q) begin
				byte_count_d       = '0;
				frame_size_d       = '0;
				length_seen_d      = '0;
				header_size_d      = '0;
				running_sum_d      = '0;
				ticks_left_d       = timeout_q;
				res_valid          = 1'b1;
				res.kind           = (running_sum_q == b) ? kfr_pkg::KIND_GOOD
				                                          : kfr_pkg::KIND_BAD;
				res.data           = b;
				res.payload_length = length_seen_q[6:0];
			end else if (frame_size_q != '0 && 8'(byte_count_q) >= 8'(header_size_q)) begin
				running_sum_d      = running_sum_q + b;
				byte_count_d       = count_inc;
				res_valid          = 1'b1;
				res.kind           = kfr_pkg::KIND_PAYLOAD;
				res.data           = b;
				res.position       = pos_full[6:0];
				res.payload_length = length_seen_q[6:0];
			end else begin
				running_sum_d = running_sum_q + b;
				byte_count_d  = count_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= kfr_pkg::TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_left_q  <= kfr_pkg::TIMEOUT_RESET;
			byte_count_q  <= '0;
			frame_size_q  <= '0;
			length_seen_q <= '0;
			header_size_q <= '0;
			running_sum_q <= '0;
		end else begin
			ticks_left_q  <= ticks_left_d;
			byte_count_q  <= byte_count_d;
			frame_size_q  <= frame_size_d;
			length_seen_q <= length_seen_d;
			header_size_q <= header_size_d;
			running_sum_q <= running_sum_d;
		end
	end

endmodule

>>> rtl/kfr_out_reg.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one result transaction until the receiving side takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kfr_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load_en,
	input  logic             res_valid,
	input  kfr_pkg::result_t res,
	output logic             valid_s2,
	output kfr_pkg::result_t result_s2
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_en) begin
			valid_s2 <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_en && res_valid) begin
			result_s2 <= res;
		end
	end

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// K-line frame receiver testbench
// Feeds line bytes and millisecond ticks through the receiver and checks every
// result transaction, field by field, against a frame parser kept in step here.
// Directed frames come first, followed by random phases at several timeout
// settings, with random idling on both sides and long receiver hold-offs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	localparam int CYCLE_LIMIT = 300000;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            in_valid = 1'b0;
	logic            in_stall;
	kfr_pkg::cmd_t   cmd = kfr_pkg::CMD_BYTE;
	logic [7:0]      rx_byte = 8'h00;
	logic            out_valid;
	logic            out_stall = 1'b0;
	logic [1:0]      kind;
	logic [7:0]      data;
	logic [6:0]      position;
	logic [6:0]      payload_length;
	logic            cfg_valid = 1'b0;
	logic            cfg_ready;
	logic [15:0]     cfg_data = 16'h0000;

	kfr_pkg::item_t   pending_items [$];
	kfr_pkg::result_t expected_results [$];
	kfr_pkg::item_t   offered;
	int      items_queued = 0;
	int      items_accepted = 0;
	int      results_seen = 0;
	int      error_count = 0;
	int      cycle_count = 0;
	int      gap_left = 0;
	int      stall_left = 0;
	int      hold_left = 0;
	int      idle_rate = 0;
	int      stall_rate = 0;

	logic [15:0] tick_budget = kfr_pkg::TIMEOUT_RESET;
	logic [15:0] ticks_remaining = kfr_pkg::TIMEOUT_RESET;
	logic [6:0]  bytes_taken = '0;
	logic [7:0]  payload_len = '0;
	logic [2:0]  header_len = '0;
	logic [6:0]  frame_len = '0;
	logic [7:0]  checksum_acc = '0;

	kline_frame_receiver i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.data           (data),
		.position       (position),
		.payload_length (payload_length),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic void restart_hunt();
		bytes_taken = '0;
		payload_len = '0;
		header_len = '0;
		frame_len = '0;
		checksum_acc = '0;
	endfunction

	function automatic bit parse_line_item(input kfr_pkg::item_t it,
			output kfr_pkg::result_t res);
		int total;
		res = '0;
		if (it.cmd == kfr_pkg::CMD_TICK) begin
			if (ticks_remaining <= 16'd1) begin
				restart_hunt();
				ticks_remaining = tick_budget;
				res.kind = kfr_pkg::KIND_TIMEOUT;
				return 1'b1;
			end
			ticks_remaining = ticks_remaining - 16'd1;
			return 1'b0;
		end
		if (bytes_taken == 0) begin
			if ((it.rx_byte & kfr_pkg::FMT_MASK) != kfr_pkg::FMT_MARK)
				return 1'b0;
			payload_len = it.rx_byte & kfr_pkg::LEN_MASK;
			header_len = (payload_len != 0) ? kfr_pkg::HDR_SHORT : kfr_pkg::HDR_LONG;
			frame_len = '0;
			if (payload_len != 0) begin
				total = int'(header_len) + int'(payload_len) + 1;
				if (total > kfr_pkg::MAX_FRAME_DEF) begin
					restart_hunt();
					return 1'b0;
				end
				frame_len = 7'(total);
			end
			checksum_acc = it.rx_byte;
			bytes_taken = 7'd1;
			return 1'b0;
		end
		if (frame_len == 0 && bytes_taken == 7'd3) begin
			total = int'(header_len) + int'(it.rx_byte) + 1;
			if (it.rx_byte == 0 || total > kfr_pkg::MAX_FRAME_DEF) begin
				restart_hunt();
				return 1'b0;
			end
			payload_len = it.rx_byte;
			frame_len = 7'(total);
			checksum_acc = checksum_acc + it.rx_byte;
			bytes_taken = 7'd4;
			return 1'b0;
		end
		if (frame_len != 0 && int'(bytes_taken) + 1 == int'(frame_len)) begin
			res.kind = (checksum_acc == it.rx_byte) ? kfr_pkg::KIND_GOOD : kfr_pkg::KIND_BAD;
			res.data = it.rx_byte;
			res.payload_length = 7'(payload_len);
			restart_hunt();
			ticks_remaining = tick_budget;
			return 1'b1;
		end
		if (frame_len != 0 && bytes_taken >= header_len) begin
			res.kind = kfr_pkg::KIND_PAYLOAD;
			res.data = it.rx_byte;
			res.position = 7'(int'(bytes_taken) - int'(header_len));
			res.payload_length = 7'(payload_len);
			checksum_acc = checksum_acc + it.rx_byte;
			bytes_taken = bytes_taken + 7'd1;
			return 1'b1;
		end
		checksum_acc = checksum_acc + it.rx_byte;
		bytes_taken = bytes_taken + 7'd1;
		return 1'b0;
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			error_count++;
		end
	endfunction

	function automatic void push_byte(input logic [7:0] value);
		kfr_pkg::item_t it;
		it.cmd = kfr_pkg::CMD_BYTE;
		it.rx_byte = value;
		pending_items.push_back(it);
		items_queued++;
	endfunction

	function automatic void push_tick();
		kfr_pkg::item_t it;
		it.cmd = kfr_pkg::CMD_TICK;
		it.rx_byte = 8'($urandom);
		pending_items.push_back(it);
		items_queued++;
	endfunction

	// Cut 0 or cut >= frame size sends the whole frame, else its first cut bytes.
	function automatic int queue_frame(input int len, input bit long_hdr, input bit good_sum,
			input int cut, input bit with_ticks);
		logic [7:0] frame_bytes [$];
		logic [7:0] sum;
		int n;
		sum = '0;
		frame_bytes.push_back(long_hdr ? kfr_pkg::FMT_MARK : (kfr_pkg::FMT_MARK | 8'(len)));
		frame_bytes.push_back(8'($urandom));
		frame_bytes.push_back(8'($urandom));
		if (long_hdr)
			frame_bytes.push_back(8'(len));
		repeat (len) frame_bytes.push_back(8'($urandom));
		foreach (frame_bytes[i]) sum = sum + frame_bytes[i];
		frame_bytes.push_back(good_sum ? sum : sum ^ 8'($urandom_range(1, 255)));
		n = (cut > 0 && cut < frame_bytes.size()) ? cut : frame_bytes.size();
		for (int i = 0; i < n; i++) begin
			if (with_ticks && $urandom_range(0, 19) == 0)
				push_tick();
			push_byte(frame_bytes[i]);
		end
		return n;
	endfunction

	task automatic queue_random_traffic(input int target);
		int queued;
		int pick;
		int len;
		bit long_hdr;
		queued = 0;
		while (queued < target) begin
			pick = $urandom_range(0, 99);
			long_hdr = ($urandom_range(0, 2) == 0);
			len = $urandom_range(1, 8);
			if (pick < 2)
				len = long_hdr ? $urandom_range(50, 75) : $urandom_range(40, 63);
			if (pick < 70) begin
				queued += queue_frame(len, long_hdr, $urandom_range(0, 5) != 0, 0, 1'b1);
			end else if (pick < 80) begin
				queued += queue_frame(len, long_hdr, 1'b1, $urandom_range(1, len + 2), 1'b1);
			end else if (pick < 86) begin
				len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(76, 255);
				queued += queue_frame(len, 1'b1, 1'b1, 4, 1'b0);
			end else if (pick < 94) begin
				repeat ($urandom_range(1, 4)) begin
					push_tick();
					queued++;
				end
			end else begin
				push_byte(8'($urandom));
			end
		end
	endtask

	task automatic wait_drained();
		while (items_accepted != items_queued || expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [15:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tick_budget = value;
	endtask

	always @(posedge clk) begin : drive_items
		kfr_pkg::result_t outcome;
		if (in_valid && !in_stall) begin
			if (parse_line_item(offered, outcome))
				expected_results.push_back(outcome);
			items_accepted++;
		end
		if (!in_valid || !in_stall) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (idle_rate != 0 && $urandom_range(1, idle_rate) == 1) begin
				in_valid <= 1'b0;
				gap_left = $urandom_range(0, 4);
			end else if (pending_items.size() != 0) begin
				offered = pending_items.pop_front();
				in_valid <= 1'b1;
				cmd <= offered.cmd;
				rx_byte <= offered.rx_byte;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : check_results
		kfr_pkg::result_t want;
		if (out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual kind %0d data %0d",
					$time, kind, data);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("kind", int'(want.kind), int'(kind));
				check_field("data", int'(want.data), int'(data));
				check_field("position", int'(want.position), int'(position));
				check_field("payload_length", int'(want.payload_length), int'(payload_length));
			end
			results_seen++;
			if (results_seen == 150 || results_seen == 350)
				hold_left = 300;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (stall_rate != 0 && $urandom_range(1, stall_rate) == 1) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 4);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	initial begin : stimulus
		logic [15:0] timeout_plan [0:6];
		int phase;
		timeout_plan = '{16'hFFFF, 16'd1, 16'd0, 16'd5, 16'd0, kfr_pkg::TIMEOUT_RESET, 16'd20};
		timeout_plan[4] = 16'($urandom_range(2, 30));
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The budget of 400 loaded at reset stays until the first frame end reloads it.
		write_timeout(16'd3);
		idle_rate = 6;
		stall_rate = 6;
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h40);
		void'(queue_frame(1, 1'b0, 1'b1, 0, 1'b0));
		void'(queue_frame(2, 1'b0, 1'b0, 0, 1'b0));
		void'(queue_frame(0, 1'b1, 1'b1, 4, 1'b0));
		void'(queue_frame(255, 1'b1, 1'b1, 4, 1'b0));
		repeat (3) push_tick();
		wait_drained();

		for (phase = 0; phase < 7; phase++) begin
			write_timeout(timeout_plan[phase]);
			idle_rate = (phase == 2 || phase == 6) ? 0 : $urandom_range(3, 10);
			stall_rate = (phase == 2 || phase == 6) ? 0 : $urandom_range(3, 10);
			queue_random_traffic(118);
			wait_drained();
		end

		if (error_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/kfr_pkg.sv
rtl/kfr_in_reg.sv
rtl/kfr_parser.sv
rtl/kfr_out_reg.sv
rtl/kline_frame_receiver.sv
tb/sv/tb.sv
